>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCSD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UCSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ucsd_pkg.sv
`timescale 1ns / 1ps

package ucsd_pkg;

	localparam int unsigned OPCODE_COUNT = 224;
	localparam int unsigned MAX_PARAMS   = 3;
	localparam int unsigned SLOT_COUNT   = 3;

	typedef enum logic [3:0] {
		KIND_OPCODE   = 4'd0,
		KIND_SHORT    = 4'd1,
		KIND_WORD     = 4'd2,
		KIND_STR_BYTE = 4'd3,
		KIND_STR_END  = 4'd4,
		KIND_BIN_LEN  = 4'd5,
		KIND_BIN_BYTE = 4'd6,
		KIND_ERROR    = 4'd7,
		KIND_END      = 4'd8
	} token_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE           = 2'd0,
		ERR_ILLEGAL_OPCODE = 2'd1,
		ERR_UNEXPECTED_END = 2'd2
	} error_code_t;

	typedef enum logic [2:0] {
		PT_NONE  = 3'd0,
		PT_SHORT = 3'd1,
		PT_WORD  = 3'd2,
		PT_STR   = 3'd3,
		PT_BIN   = 3'd4
	} param_type_t;

	typedef enum logic [5:0] {
		PH_OPCODE   = 6'b000001,
		PH_SHORT    = 6'b000010,
		PH_WORD     = 6'b000100,
		PH_STR      = 6'b001000,
		PH_BIN_LEN  = 6'b010000,
		PH_BIN_BODY = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} stream_item_t;

	typedef struct packed {
		logic [3:0]         token_kind;
		logic [7:0]         opcode_value;
		logic [1:0]         param_slot;
		logic signed [31:0] param_value;
		logic [7:0]         payload_byte;
		logic [1:0]         error_code;
		logic               instruction_last;
	} token_item_t;

	typedef struct packed {
		logic             valid;
		logic [2:0][2:0]  types;
	} rom_entry_t;

	typedef struct packed {
		logic       found;
		logic [1:0] slot;
		logic [2:0] ptype;
	} slot_pick_t;

	// Descriptor ROM: legality and the parameter type of each slot.
	function automatic rom_entry_t rom_lookup(logic [7:0] op);
		rom_entry_t e;
		e = '0;
		e.valid = (op >= 8'd1 && op <= 8'd78) || (op >= 8'd80 && op <= 8'd89) ||
			(op == 8'd98) || (op >= 8'd201 && op <= 8'd215) ||
			(op >= 8'd217 && op <= 8'd223);
		case (op)
			8'd46, 8'd50, 8'd51, 8'd58, 8'd59, 8'd60, 8'd61,
			8'd64, 8'd67, 8'd75, 8'd77, 8'd80, 8'd213, 8'd219: begin
				e.types[0] = PT_SHORT;
			end
			8'd65: begin
				e.types[0] = PT_WORD;
			end
			8'd57, 8'd62, 8'd84, 8'd201, 8'd204, 8'd205, 8'd207,
			8'd208, 8'd211, 8'd212, 8'd214, 8'd215, 8'd220, 8'd222: begin
				e.types[0] = PT_STR;
			end
			8'd83, 8'd210, 8'd221: begin
				e.types[0] = PT_WORD;
				e.types[1] = PT_STR;
			end
			8'd206: begin
				e.types[0] = PT_WORD;
				e.types[1] = PT_BIN;
			end
			8'd209: begin
				e.types[0] = PT_STR;
				e.types[1] = PT_SHORT;
			end
			8'd223: begin
				e.types[0] = PT_STR;
				e.types[1] = PT_STR;
			end
			default: begin
			end
		endcase
		if (!e.valid) begin
			e.types = '0;
		end
		return e;
	endfunction

	function automatic logic opcode_legal(logic [7:0] op);
		rom_entry_t e;
		e = rom_lookup(op);
		return (op != 8'd0) && (int'(op) < OPCODE_COUNT) && e.valid;
	endfunction

	// First occupied slot at or after the given one; slots past the limit count as empty.
	function automatic slot_pick_t next_slot(logic [2:0][2:0] types, logic [2:0] first);
		slot_pick_t pick;
		pick = '0;
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			if (s >= int'(first) && s < int'(MAX_PARAMS) && types[s] != PT_NONE) begin
				pick.found = 1'b1;
				pick.slot  = 2'(s);
				pick.ptype = types[s];
			end
		end
		return pick;
	endfunction

	function automatic phase_t phase_of(logic [2:0] ptype);
		phase_t ph;
		case (ptype)
			PT_SHORT: ph = PH_SHORT;
			PT_WORD:  ph = PH_WORD;
			PT_STR:   ph = PH_STR;
			PT_BIN:   ph = PH_BIN_LEN;
			default:  ph = PH_OPCODE;
		endcase
		return ph;
	endfunction

endpackage

>>> sv/ucsd_in_stage.sv
`timescale 1ns / 1ps

module ucsd_in_stage import ucsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         stream_valid,
	output logic         stream_stall,
	input  stream_item_t stream_item,
	input  logic         take,
	output logic         valid_s1,
	output stream_item_t item_s1
);

	logic load;

	// The held item blocks new ones only while the parser cannot take it.
	assign stream_stall = valid_s1 && !take;
	assign load         = stream_valid && !stream_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= stream_item;
		end
	end

endmodule

>>> sv/ucsd_parser.sv
`timescale 1ns / 1ps

module ucsd_parser import ucsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  stream_item_t item,
	output logic         tok_valid,
	output token_item_t  tok
);

	phase_t      phase_q, phase_d;
	logic [7:0]  op_q, op_d;
	logic [1:0]  slot_q, slot_d;
	logic [15:0] cnt_q, cnt_d;
	logic [31:0] acc_q, acc_d;
	logic        err_q, err_d;

	rom_entry_t  cur_entry;
	rom_entry_t  new_entry;
	slot_pick_t  pick_next;
	slot_pick_t  pick_first;
	slot_pick_t  pick;
	logic        enter;
	logic        from_opcode;
	logic [31:0] acc_new;
	logic [15:0] bin_len;
	logic [7:0]  b;

	assign b          = item.data_byte;
	assign cur_entry  = rom_lookup(op_q);
	assign new_entry  = rom_lookup(b);
	assign pick_next  = next_slot(cur_entry.types, {1'b0, slot_q} + 3'd1);
	assign pick_first = next_slot(new_entry.types, 3'd0);
	assign bin_len    = acc_new[15:0];

	always_comb begin
		phase_d     = phase_q;
		op_d        = op_q;
		slot_d      = slot_q;
		cnt_d       = cnt_q;
		acc_d       = acc_q;
		err_d       = err_q;
		tok         = '0;
		tok_valid   = 1'b0;
		enter       = 1'b0;
		from_opcode = 1'b0;
		acc_new     = acc_q;
		pick        = pick_next;

		if (err_q) begin
			tok_valid = 1'b0;
		end else if (item.end_of_input) begin
			tok_valid = 1'b1;
			if (phase_q == PH_OPCODE) begin
				tok.token_kind = KIND_END;
			end else begin
				tok.token_kind   = KIND_ERROR;
				tok.opcode_value = op_q;
				tok.param_slot   = slot_q;
				tok.error_code   = ERR_UNEXPECTED_END;
				err_d            = 1'b1;
			end
		end else begin
			tok.opcode_value = op_q;
			tok.param_slot   = slot_q;
			case (phase_q)
				PH_OPCODE: begin
					tok_valid        = 1'b1;
					tok.opcode_value = b;
					tok.param_slot   = 2'd0;
					if (!opcode_legal(b)) begin
						tok.token_kind = KIND_ERROR;
						tok.error_code = ERR_ILLEGAL_OPCODE;
						err_d          = 1'b1;
					end else begin
						tok.token_kind = KIND_OPCODE;
						op_d           = b;
						enter          = 1'b1;
						from_opcode    = 1'b1;
					end
				end
				PH_SHORT: begin
					acc_new = acc_q | (32'(b) << {cnt_q[1:0], 3'b000});
					if (cnt_q == 16'd0) begin
						acc_d = acc_new;
						cnt_d = cnt_q + 16'd1;
					end else begin
						tok_valid       = 1'b1;
						tok.token_kind  = KIND_SHORT;
						tok.param_value = {{16{acc_new[15]}}, acc_new[15:0]};
						enter           = 1'b1;
					end
				end
				PH_WORD: begin
					acc_new = acc_q | (32'(b) << {cnt_q[1:0], 3'b000});
					if (cnt_q < 16'd3) begin
						acc_d = acc_new;
						cnt_d = cnt_q + 16'd1;
					end else begin
						tok_valid       = 1'b1;
						tok.token_kind  = KIND_WORD;
						tok.param_value = acc_new;
						enter           = 1'b1;
					end
				end
				PH_STR: begin
					tok_valid = 1'b1;
					if (b != 8'd0) begin
						tok.token_kind   = KIND_STR_BYTE;
						tok.payload_byte = b;
					end else begin
						tok.token_kind = KIND_STR_END;
						enter          = 1'b1;
					end
				end
				PH_BIN_LEN: begin
					acc_new = acc_q | (32'(b) << {1'b0, cnt_q[0], 3'b000});
					if (cnt_q == 16'd0) begin
						acc_d = acc_new;
						cnt_d = cnt_q + 16'd1;
					end else begin
						tok_valid       = 1'b1;
						tok.token_kind  = KIND_BIN_LEN;
						tok.param_value = {16'd0, bin_len};
						if (bin_len == 16'd0) begin
							enter = 1'b1;
						end else begin
							phase_d = PH_BIN_BODY;
							cnt_d   = bin_len;
							acc_d   = '0;
						end
					end
				end
				PH_BIN_BODY: begin
					tok_valid        = 1'b1;
					tok.token_kind   = KIND_BIN_BYTE;
					tok.payload_byte = b;
					cnt_d            = cnt_q - 16'd1;
					if (cnt_q == 16'd1) begin
						enter = 1'b1;
					end
				end
				default: begin
					phase_d = PH_OPCODE;
				end
			endcase
		end

		// Move on to the next occupied slot, or back to expecting an opcode.
		if (enter) begin
			if (from_opcode) begin
				pick = pick_first;
			end
			cnt_d = '0;
			acc_d = '0;
			if (pick.found) begin
				phase_d = phase_of(pick.ptype);
				slot_d  = pick.slot;
			end else begin
				phase_d = PH_OPCODE;
				slot_d  = 2'd0;
			end
			tok.instruction_last = !pick.found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			op_q    <= '0;
			slot_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			slot_q  <= slot_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			err_q   <= err_d;
		end
	end

endmodule

>>> sv/ucsd_out_stage.sv
`timescale 1ns / 1ps

module ucsd_out_stage import ucsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  token_item_t tok,
	output logic        ready,
	output logic        token_valid,
	input  logic        token_stall,
	output token_item_t token_item
);

	logic        valid_s2;
	token_item_t item_s2;

	// A new token may enter when the register is empty or is being emptied now.
	assign ready       = !valid_s2 || !token_stall;
	assign token_valid = valid_s2;
	assign token_item  = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			item_s2 <= tok;
		end
	end

endmodule

>>> sv/ucode_stream_deframer.sv
`timescale 1ns / 1ps

// Splits a byte stream of compiled intermediate code into tokens.
// Input channel (stream_valid, stream_stall, stream_item): one item is one
// stream byte, or an end-of-input event when end_of_input is set.
// Output channel (token_valid, token_stall, token_item): at most one token
// per input item: opcodes, parameter values, string and binary bytes, an
// error token, or a clean-end token. instruction_last marks the final token
// of each instruction.
// Throughput is one item per cycle while token_stall is low, with no gaps
// between items. An accepted item is held in the input register, parsed,
// and its token goes into the output register that drives token_valid.
// Items that only carry part of a multi-byte value yield no token. The
// parser state advances once per accepted item, which sets the rate.
// When token_stall is held, the output register keeps its token and the
// input register holds one more item; stream_stall then rises.
// Reset clears both registers and the parser to expecting an opcode. After
// an error token no further tokens come until the next reset.

module ucode_stream_deframer import ucsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         stream_valid,
	output logic         stream_stall,
	input  stream_item_t stream_item,
	output logic         token_valid,
	input  logic         token_stall,
	output token_item_t  token_item
);

	logic         valid_s1;
	stream_item_t item_s1;
	logic         out_ready;
	logic         step;
	logic         tok_valid;
	token_item_t  tok;

	// The held item is parsed in the cycle that the output register can
	// take its result; items without a token pass through just the same.
	assign step = valid_s1 && out_ready;

	ucsd_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.stream_item  (stream_item),
		.take         (step),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	ucsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.tok_valid (tok_valid),
		.tok       (tok)
	);

	ucsd_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (step && tok_valid),
		.tok         (tok),
		.ready       (out_ready),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

endmodule

>>> sv/ucsd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ucsd_checker import ucsd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         stream_valid,
	input logic         stream_stall,
	input stream_item_t stream_item,
	input logic         token_valid,
	input logic         token_stall,
	input token_item_t  token_item
);

	logic tok_taken;
	logic kind_error;
	logic kind_end;
	logic kind_content;

	assign tok_taken    = token_valid && !token_stall;
	assign kind_error   = token_item.token_kind == KIND_ERROR;
	assign kind_end     = token_item.token_kind == KIND_END;
	assign kind_content = (token_item.token_kind == KIND_STR_BYTE) ||
		(token_item.token_kind == KIND_BIN_BYTE);

	`UCSD_ASSERT_NEXT(a_stream_hold, stream_valid && stream_stall,
		stream_valid && $stable(stream_item), "stalled stream item changed")
	`UCSD_ASSERT_NEXT(a_token_hold, token_valid && token_stall,
		token_valid && $stable(token_item), "stalled token changed")
	`UCSD_ASSERT_NEXT(a_error_silent, tok_taken && kind_error,
		!token_valid, "token emitted after an error")
	`UCSD_ASSERT_IMP(a_no_last_on_end, token_valid && (kind_error || kind_end),
		!token_item.instruction_last, "end or error token marked last")
	`UCSD_ASSERT_IMP(a_payload_zero, token_valid && !kind_content,
		token_item.payload_byte == 8'd0, "payload byte set on a non-content token")

endmodule

bind ucode_stream_deframer ucsd_checker u_checker (.*);
